// ===== src/fof_pkg.sv =====
// shared types, constants and helper functions of the orthonormal frame pipeline
package fof_pkg;

  localparam int MAG_W      = 31;
  localparam int SV_W       = 32;
  localparam int PROD_W     = 64;
  localparam int RAD_W      = 64;
  localparam int ROOT_W     = 32;
  localparam int SQRT_STEPS = 32;
  localparam int SHIFT_W    = 6;
  localparam int LIM_BITS   = 31;

  typedef logic [MAG_W-1:0]         mag_t;
  typedef logic signed [SV_W-1:0]   sv_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    mag_t [2:0] mag;
    logic [2:0] sg;
  } vec_t;

  typedef struct packed {
    vec_t               a;
    vec_t               c;
    vec_t               w;
    logic [SHIFT_W-1:0] sc;
    logic               deg;
  } side_t;

  // smallest right shift that brings the largest magnitude below 2^31
  function automatic logic [SHIFT_W-1:0] shift_cnt(input logic [63:0] m);
    logic [6:0] bl;
    bl = '0;
    for (int i = 0; i < 64; i++) begin
      if (m[i]) bl = 7'(i + 1);
    end
    return (bl > 7'(LIM_BITS)) ? SHIFT_W'(bl - 7'(LIM_BITS)) : '0;
  endfunction

  function automatic sv_t to_sv(input mag_t m, input logic neg);
    sv_t v;
    v = sv_t'({1'b0, m});
    return neg ? -v : v;
  endfunction

endpackage

// ===== src/fof_isqrt.sv =====
// pipelined 64-bit integer square root, one result bit per stage
module fof_isqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [fof_pkg::RAD_W-1:0]   rad,
  output logic [fof_pkg::ROOT_W-1:0]  root
);

  localparam int STEPS = fof_pkg::SQRT_STEPS;
  localparam int RW    = fof_pkg::RAD_W;

  logic [RW-1:0] n_q [STEPS];
  logic [RW-1:0] r_q [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [RW-1:0] BIT = RW'(1) << (RW - 2 - 2 * k);
    logic [RW-1:0] n_src;
    logic [RW-1:0] r_src;
    logic [RW-1:0] trial;

    if (k == 0) begin : g_first
      assign n_src = rad;
      assign r_src = '0;
    end else begin : g_next
      assign n_src = n_q[k-1];
      assign r_src = r_q[k-1];
    end

    assign trial = r_src + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (n_src >= trial) begin
          n_q[k] <= n_src - trial;
          r_q[k] <= (r_src >> 1) + BIT;
        end else begin
          n_q[k] <= n_src;
          r_q[k] <= r_src >> 1;
        end
      end
    end
  end

  assign root = r_q[STEPS-1][fof_pkg::ROOT_W-1:0];

endmodule

// ===== src/fof_div.sv =====
// pipelined restoring divider: integer bit plus FRAC fraction bits, one bit per stage
module fof_div #(
  parameter int W    = 32,
  parameter int FRAC = 31
) (
  input  logic          clk,
  input  logic          en,
  input  logic [W-1:0]  num,
  input  logic [W-1:0]  den,
  output logic [FRAC:0] quo,
  output logic          sat
);

  logic [W-1:0]  rem_q [FRAC+1];
  logic [W-1:0]  den_q [FRAC+1];
  logic [FRAC:0] q_q   [FRAC+1];
  logic          sat_q [FRAC+1];
  logic          ge0;

  assign ge0 = num >= den;

  // quotient of two or more overflows the result range
  always_ff @(posedge clk) begin
    if (en) begin
      sat_q[0] <= {1'b0, num} >= {den, 1'b0};
      rem_q[0] <= ge0 ? num - den : num;
      q_q[0]   <= (FRAC + 1)'(ge0);
      den_q[0] <= den;
    end
  end

  for (genvar k = 1; k <= FRAC; k++) begin : g_step
    logic [W:0] r2;
    logic [W:0] diff;
    logic       ge;

    assign r2   = {rem_q[k-1], 1'b0};
    assign diff = r2 - {1'b0, den_q[k-1]};
    assign ge   = r2 >= {1'b0, den_q[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? diff[W-1:0] : r2[W-1:0];
        q_q[k]   <= {q_q[k-1][FRAC-1:0], ge};
        den_q[k] <= den_q[k-1];
        sat_q[k] <= sat_q[k-1];
      end
    end
  end

  assign quo = q_q[FRAC];
  assign sat = sat_q[FRAC];

endmodule

// ===== src/orthonormal_frame_from_two_vectors.sv =====
// orthonormal frame from two 3d vectors: block shift, cross products, lengths, unit axes
//
//  channel | dir | tdata (low bits up)                            | tuser
//  s_*     | in  | first_x first_y first_z second_x second_y second_z | -
//  m_*     | out | m_xx m_yx m_zx m_xy m_yy m_zy m_xz m_yz m_zz health | degenerate
//
// one word per cycle in and out while the output is not stalled; the pipeline depth is
// set by the 32-stage square root and the OUT_FRAC_BITS + 2 stage dividers
// a stalled output word freezes the whole pipeline; s_tready follows it
// synchronous reset clears only the valid bits, no clearing pass
module orthonormal_frame_from_two_vectors #(
  parameter int IN_WIDTH      = 32,
  parameter int OUT_FRAC_BITS = 30,
  localparam int S_W = ((6 * IN_WIDTH + 7) / 8) * 8,
  localparam int AW  = OUT_FRAC_BITS + 2,
  localparam int HW  = OUT_FRAC_BITS + 1,
  localparam int M_W = ((9 * AW + HW + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [S_W-1:0] s_tdata,  // first_x, first_y, first_z, second_x, second_y, second_z
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [M_W-1:0] m_tdata,  // m_xx m_yx m_zx m_xy m_yy m_zy m_xz m_yz m_zz health
  output logic           m_tuser   // degenerate
);

  localparam int FRAC    = OUT_FRAC_BITS + 1;
  localparam int DIV_LAT = FRAC + 1;
  localparam int QW      = FRAC + 1;
  localparam int FRONT   = 13;
  localparam int LAT     = FRONT + fof_pkg::SQRT_STEPS + 1 + DIV_LAT + 1;
  localparam logic [QW-1:0] CAP = QW'(1) << OUT_FRAC_BITS;

  logic           en;
  logic [LAT-1:0] vld;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // stage 1: magnitudes of the input components
  logic [IN_WIDTH-1:0] in_mag [6];
  logic [5:0]          in_sg;
  logic [IN_WIDTH-1:0] r1_mag [6];
  logic [5:0]          r1_sg;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      in_sg[k]  = s_tdata[k * IN_WIDTH + IN_WIDTH - 1];
      in_mag[k] = in_sg[k] ? -s_tdata[k * IN_WIDTH +: IN_WIDTH]
                           : s_tdata[k * IN_WIDTH +: IN_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_mag <= in_mag;
      r1_sg  <= in_sg;
    end
  end

  // stage 2: block shift of both inputs
  logic [IN_WIDTH-1:0]         or_a, or_b;
  logic [fof_pkg::SHIFT_W-1:0] sa, sb;
  logic [63:0]                 sh_in [6];
  fof_pkg::side_t              r2_sd_next;
  fof_pkg::vec_t               r2_b_next;
  fof_pkg::side_t              r2_sd;
  fof_pkg::vec_t               r2_b;

  always_comb begin
    or_a = r1_mag[0] | r1_mag[1] | r1_mag[2];
    or_b = r1_mag[3] | r1_mag[4] | r1_mag[5];
    sa   = fof_pkg::shift_cnt(64'(or_a));
    sb   = fof_pkg::shift_cnt(64'(or_b));
    r2_sd_next = '0;
    r2_b_next  = '0;
    for (int k = 0; k < 3; k++) begin
      sh_in[k]     = 64'(r1_mag[k]) >> sa;
      sh_in[k + 3] = 64'(r1_mag[k + 3]) >> sb;
      r2_sd_next.a.mag[k] = sh_in[k][fof_pkg::MAG_W-1:0];
      r2_b_next.mag[k]    = sh_in[k + 3][fof_pkg::MAG_W-1:0];
    end
    r2_sd_next.a.sg = r1_sg[2:0];
    r2_b_next.sg    = r1_sg[5:3];
    r2_sd_next.deg  = (or_a == '0) || (or_b == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2_sd <= r2_sd_next;
      r2_b  <= r2_b_next;
    end
  end

  // stage 3: products for c = a x b
  fof_pkg::sv_t   av2 [3], bv2 [3];
  fof_pkg::prod_t r3_p [6];
  fof_pkg::side_t r3_sd;
  fof_pkg::vec_t  r3_b;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      av2[k] = fof_pkg::to_sv(r2_sd.a.mag[k], r2_sd.a.sg[k]);
      bv2[k] = fof_pkg::to_sv(r2_b.mag[k], r2_b.sg[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r3_p[0] <= av2[1] * bv2[2];
      r3_p[1] <= av2[2] * bv2[1];
      r3_p[2] <= av2[2] * bv2[0];
      r3_p[3] <= av2[0] * bv2[2];
      r3_p[4] <= av2[0] * bv2[1];
      r3_p[5] <= av2[1] * bv2[0];
      r3_sd   <= r2_sd;
      r3_b    <= r2_b;
    end
  end

  // stage 4: cross product differences
  fof_pkg::prod_t r4_c [3];
  fof_pkg::side_t r4_sd;
  fof_pkg::vec_t  r4_b;

  always_ff @(posedge clk) begin
    if (en) begin
      r4_c[0] <= r3_p[0] - r3_p[1];
      r4_c[1] <= r3_p[2] - r3_p[3];
      r4_c[2] <= r3_p[4] - r3_p[5];
      r4_sd   <= r3_sd;
      r4_b    <= r3_b;
    end
  end

  // stage 5: magnitude of c, parallel inputs flagged here
  logic [63:0]    c_abs [3];
  fof_pkg::side_t r5_sd_next;
  logic [62:0]    r5_cmag [3];
  logic [2:0]     r5_csg;
  fof_pkg::side_t r5_sd;
  fof_pkg::vec_t  r5_b;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c_abs[k] = r4_c[k][63] ? 64'(-r4_c[k]) : 64'(r4_c[k]);
    end
    r5_sd_next     = r4_sd;
    r5_sd_next.deg = r4_sd.deg || (r4_c[0] == 0 && r4_c[1] == 0 && r4_c[2] == 0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        r5_cmag[k] <= c_abs[k][62:0];
      end
      r5_csg <= {r4_c[2][63], r4_c[1][63], r4_c[0][63]};
      r5_sd  <= r5_sd_next;
      r5_b   <= r4_b;
    end
  end

  // stage 6: block shift of c
  logic [fof_pkg::SHIFT_W-1:0] sc;
  logic [63:0]                 sh_c [3];
  fof_pkg::side_t              r6_sd_next;
  fof_pkg::side_t              r6_sd;
  fof_pkg::vec_t               r6_b;

  always_comb begin
    sc = fof_pkg::shift_cnt(64'(r5_cmag[0] | r5_cmag[1] | r5_cmag[2]));
    r6_sd_next = r5_sd;
    for (int k = 0; k < 3; k++) begin
      sh_c[k] = 64'(r5_cmag[k]) >> sc;
      r6_sd_next.c.mag[k] = sh_c[k][fof_pkg::MAG_W-1:0];
    end
    r6_sd_next.c.sg = r5_csg;
    r6_sd_next.sc   = sc;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r6_sd <= r6_sd_next;
      r6_b  <= r5_b;
    end
  end

  // stage 7: products for w = c x a
  fof_pkg::sv_t   cv6 [3], av6 [3];
  fof_pkg::prod_t r7_p [6];
  fof_pkg::side_t r7_sd;
  fof_pkg::vec_t  r7_b;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cv6[k] = fof_pkg::to_sv(r6_sd.c.mag[k], r6_sd.c.sg[k]);
      av6[k] = fof_pkg::to_sv(r6_sd.a.mag[k], r6_sd.a.sg[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r7_p[0] <= cv6[1] * av6[2];
      r7_p[1] <= cv6[2] * av6[1];
      r7_p[2] <= cv6[2] * av6[0];
      r7_p[3] <= cv6[0] * av6[2];
      r7_p[4] <= cv6[0] * av6[1];
      r7_p[5] <= cv6[1] * av6[0];
      r7_sd   <= r6_sd;
      r7_b    <= r6_b;
    end
  end

  // stage 8: w differences
  fof_pkg::prod_t r8_w [3];
  fof_pkg::side_t r8_sd;
  fof_pkg::vec_t  r8_b;

  always_ff @(posedge clk) begin
    if (en) begin
      r8_w[0] <= r7_p[0] - r7_p[1];
      r8_w[1] <= r7_p[2] - r7_p[3];
      r8_w[2] <= r7_p[4] - r7_p[5];
      r8_sd   <= r7_sd;
      r8_b    <= r7_b;
    end
  end

  // stage 9: magnitude of w
  logic [63:0]    w_abs [3];
  fof_pkg::side_t r9_sd_next;
  logic [62:0]    r9_wmag [3];
  logic [2:0]     r9_wsg;
  fof_pkg::side_t r9_sd;
  fof_pkg::vec_t  r9_b;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      w_abs[k] = r8_w[k][63] ? 64'(-r8_w[k]) : 64'(r8_w[k]);
    end
    r9_sd_next     = r8_sd;
    r9_sd_next.deg = r8_sd.deg || (r8_w[0] == 0 && r8_w[1] == 0 && r8_w[2] == 0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        r9_wmag[k] <= w_abs[k][62:0];
      end
      r9_wsg <= {r8_w[2][63], r8_w[1][63], r8_w[0][63]};
      r9_sd  <= r9_sd_next;
      r9_b   <= r8_b;
    end
  end

  // stage 10: block shift of w
  logic [fof_pkg::SHIFT_W-1:0] sw;
  logic [63:0]                 sh_w [3];
  fof_pkg::side_t              r10_sd_next;
  fof_pkg::side_t              r10_sd;
  fof_pkg::vec_t               r10_b;

  always_comb begin
    sw = fof_pkg::shift_cnt(64'(r9_wmag[0] | r9_wmag[1] | r9_wmag[2]));
    r10_sd_next = r9_sd;
    for (int k = 0; k < 3; k++) begin
      sh_w[k] = 64'(r9_wmag[k]) >> sw;
      r10_sd_next.w.mag[k] = sh_w[k][fof_pkg::MAG_W-1:0];
    end
    r10_sd_next.w.sg = r9_wsg;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r10_sd <= r10_sd_next;
      r10_b  <= r9_b;
    end
  end

  // stages 11 to 13: sums of squares of a, b, c, w
  fof_pkg::mag_t  vm [4][3];
  logic [61:0]    r11_sq [4][3];
  logic [62:0]    r12_ps [4];
  logic [61:0]    r12_sz [4];
  logic [63:0]    r13_rad [4];
  fof_pkg::side_t r11_sd, r12_sd, r13_sd;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vm[0][k] = r10_sd.a.mag[k];
      vm[1][k] = r10_b.mag[k];
      vm[2][k] = r10_sd.c.mag[k];
      vm[3][k] = r10_sd.w.mag[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int v = 0; v < 4; v++) begin
        for (int k = 0; k < 3; k++) begin
          r11_sq[v][k] <= 62'(vm[v][k]) * 62'(vm[v][k]);
        end
        r12_ps[v]  <= 63'(r11_sq[v][0]) + 63'(r11_sq[v][1]);
        r12_sz[v]  <= r11_sq[v][2];
        r13_rad[v] <= 64'(r12_ps[v]) + 64'(r12_sz[v]);
      end
      r11_sd <= r10_sd;
      r12_sd <= r11_sd;
      r13_sd <= r12_sd;
    end
  end

  // lengths: 0 a, 1 b, 2 c, 3 w
  logic [fof_pkg::ROOT_W-1:0] root [4];

  for (genvar v = 0; v < 4; v++) begin : g_len
    fof_isqrt u_isqrt (
      .clk  (clk),
      .en   (en),
      .rad  (r13_rad[v]),
      .root (root[v])
    );
  end

  fof_pkg::side_t sd_dl [fof_pkg::SQRT_STEPS];
  fof_pkg::side_t sqd;

  always_ff @(posedge clk) begin
    if (en) begin
      sd_dl[0] <= r13_sd;
      for (int i = 1; i < fof_pkg::SQRT_STEPS; i++) begin
        sd_dl[i] <= sd_dl[i-1];
      end
    end
  end

  assign sqd = sd_dl[fof_pkg::SQRT_STEPS-1];

  // divider operands; axis order a, w, c
  logic [63:0]                p_den_h, p_num_h;
  fof_pkg::mag_t              p_num [9];
  logic [fof_pkg::ROOT_W-1:0] p_den [9];
  logic [8:0]                 p_sg;
  logic                       p_deg;

  always_ff @(posedge clk) begin
    if (en) begin
      p_den_h <= 64'(root[0]) * 64'(root[1]);
      p_num_h <= 64'(root[2]) << sqd.sc;
      for (int k = 0; k < 3; k++) begin
        p_num[k]     <= sqd.a.mag[k];
        p_den[k]     <= root[0];
        p_num[k + 3] <= sqd.w.mag[k];
        p_den[k + 3] <= root[3];
        p_num[k + 6] <= sqd.c.mag[k];
        p_den[k + 6] <= root[2];
      end
      p_sg  <= {sqd.c.sg, sqd.w.sg, sqd.a.sg};
      p_deg <= sqd.deg;
    end
  end

  logic [QW-1:0] quo [10];
  logic          qsat [10];

  for (genvar j = 0; j < 9; j++) begin : g_axis
    fof_div #(.W(fof_pkg::ROOT_W), .FRAC(FRAC)) u_div (
      .clk (clk),
      .en  (en),
      .num ({1'b0, p_num[j]}),
      .den (p_den[j]),
      .quo (quo[j]),
      .sat (qsat[j])
    );
  end

  fof_div #(.W(fof_pkg::RAD_W), .FRAC(FRAC)) u_div_health (
    .clk (clk),
    .en  (en),
    .num (p_num_h),
    .den (p_den_h),
    .quo (quo[9]),
    .sat (qsat[9])
  );

  logic [9:0] fl_dl [DIV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      fl_dl[0] <= {p_deg, p_sg};
      for (int i = 1; i < DIV_LAT; i++) begin
        fl_dl[i] <= fl_dl[i-1];
      end
    end
  end

  // round half up, saturate at one
  logic [QW:0]   qp [10];
  logic [QW-1:0] rnd [10];
  logic [9:0]    fl;

  assign fl = fl_dl[DIV_LAT-1];

  always_comb begin
    for (int j = 0; j < 10; j++) begin
      qp[j]  = (QW + 1)'(quo[j]) + 1'b1;
      rnd[j] = (qsat[j] || qp[j][QW:1] > CAP) ? CAP : qp[j][QW:1];
    end
  end

  logic [AW-1:0] o_axis [9];
  logic [HW-1:0] o_health;
  logic          o_deg;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 9; j++) begin
        o_axis[j] <= fl[9] ? '0 : (fl[j] ? -AW'(rnd[j]) : AW'(rnd[j]));
      end
      o_health <= fl[9] ? '0 : rnd[9][HW-1:0];
      o_deg    <= fl[9];
    end
  end

  always_comb begin
    m_tdata = '0;
    for (int j = 0; j < 9; j++) begin
      m_tdata[j * AW +: AW] = o_axis[j];
    end
    m_tdata[9 * AW +: HW] = o_health;
  end

  assign m_tuser = o_deg;

endmodule

// ===== src/fof_checker.sv =====
// port-level checks of the orthonormal frame block, bound to the top level
module fof_checker #(
  parameter int IN_WIDTH      = 32,
  parameter int OUT_FRAC_BITS = 30,
  localparam int AW  = OUT_FRAC_BITS + 2,
  localparam int HW  = OUT_FRAC_BITS + 1,
  localparam int M_W = ((9 * AW + HW + 7) / 8) * 8
) (
  input logic           clk,
  input logic           rst,
  input logic           s_tready,
  input logic           m_tvalid,
  input logic           m_tready,
  input logic [M_W-1:0] m_tdata,  // m_xx m_yx m_zx m_xy m_yy m_zy m_xz m_yz m_zz health
  input logic           m_tuser   // degenerate
);

  localparam logic [HW-1:0] ONE = HW'(1) << OUT_FRAC_BITS;

  // a stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed under stall");

  // input is taken whenever the output side can move
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid || m_tready |-> s_tready)
    else $error("input not ready while output free");

  // degenerate frames carry all zeros
  a_degen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("degenerate word with nonzero data");

  // health never exceeds one
  a_health: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[9 * AW +: HW] <= ONE)
    else $error("health above one");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind orthonormal_frame_from_two_vectors fof_checker #(
  .IN_WIDTH      (IN_WIDTH),
  .OUT_FRAC_BITS (OUT_FRAC_BITS)
) u_fof_checker (.*);
